// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the escape sequence decoder.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, ignored while reset is held.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/esd_pkg.sv
// Types and character constants for the escape sequence decoder.
// No dependencies; used by the decode logic and the top level.
package esd_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_HEX    = 2'd2,
        MODE_OCT    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] accum;
        logic [1:0] octal_count;
        logic       warn_pending;
    } t_dec_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       octal_warn;
        logic       done_res;
    } t_result;

    localparam t_dec_state DEC_STATE_RESET = '{
        mode: MODE_NORMAL, accum: 8'd0, octal_count: 2'd0, warn_pending: 1'b0
    };

    localparam t_result RESULT_NONE = '0;

    // Escape introducer and escape letters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    // Digit ranges
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Control bytes produced by the letter escapes
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // Octal escape closes after this many digits
    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;

    // Result queue depth (an item makes at most two results)
    localparam int RESULT_DEPTH = 2;

endpackage

// File: rtl/core/esd_if.sv
// Valid/ready channel interfaces for input items and decoded results.
// No package dependencies; field widths are given directly.
interface esd_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface esd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       octal_warn;
    logic       done_res;

    modport source (output valid, output out_byte, output has_byte, output octal_warn,
                    output done_res, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input octal_warn,
                    input done_res, output ready);
endinterface

// File: rtl/core/esd_decode.sv
// Single-pass escape decode: current state plus one item gives the next state
// and up to two results. Depends on esd_pkg.
module esd_decode (
    input  esd_pkg::t_dec_state i_state,
    input  logic                i_kind,
    input  logic [7:0]          i_ch,
    output esd_pkg::t_dec_state o_next,
    output logic [1:0]          o_count,
    output esd_pkg::t_result    o_res0,
    output esd_pkg::t_result    o_res1
);

    logic       w_is_dec;
    logic       w_is_hex;
    logic [3:0] w_hex_val;
    logic [3:0] w_dec_val;
    logic       w_over_seven;

    always_comb begin
        w_dec_val    = i_ch[3:0];
        w_is_dec     = (i_ch >= esd_pkg::CH_ZERO) && (i_ch <= esd_pkg::CH_NINE);
        w_over_seven = (i_ch > esd_pkg::CH_SEVEN);
        w_is_hex     = 1'b1;
        w_hex_val    = i_ch[3:0];
        priority if (w_is_dec) begin
            w_hex_val = i_ch[3:0];
        end else if ((i_ch >= esd_pkg::CH_LOWER_A && i_ch <= esd_pkg::CH_LOWER_F)
                  || (i_ch >= esd_pkg::CH_UPPER_A && i_ch <= esd_pkg::CH_UPPER_F)) begin
            // a..f and A..F both have low nibble 1..6
            w_hex_val = i_ch[3:0] + 4'd9;
        end else begin
            w_is_hex = 1'b0;
        end
    end

    always_comb begin
        o_next  = i_state;
        o_count = 2'd0;
        o_res0  = esd_pkg::RESULT_NONE;
        o_res1  = esd_pkg::RESULT_NONE;

        if (i_kind) begin
            // flush whatever is pending, then the closing result
            unique case (i_state.mode)
                esd_pkg::MODE_ESC: begin
                    o_res0 = '{esd_pkg::CH_BACKSLASH, 1'b1, 1'b0, 1'b0};
                end
                esd_pkg::MODE_HEX: begin
                    o_res0 = '{i_state.accum, 1'b1, 1'b0, 1'b0};
                end
                esd_pkg::MODE_OCT: begin
                    o_res0 = '{i_state.accum, 1'b1, i_state.warn_pending, 1'b0};
                end
                esd_pkg::MODE_NORMAL: begin
                    o_res0 = '{8'd0, 1'b0, 1'b0, 1'b1};
                end
                default: begin
                    o_res0 = esd_pkg::RESULT_NONE;
                end
            endcase
            if (i_state.mode == esd_pkg::MODE_NORMAL) begin
                o_count = 2'd1;
            end else begin
                o_res1  = '{8'd0, 1'b0, 1'b0, 1'b1};
                o_count = 2'd2;
            end
            o_next = esd_pkg::DEC_STATE_RESET;
        end else begin
            unique case (i_state.mode)
                esd_pkg::MODE_NORMAL: begin
                    if (i_ch == esd_pkg::CH_BACKSLASH) begin
                        o_next.mode = esd_pkg::MODE_ESC;
                    end else begin
                        o_res0  = '{i_ch, 1'b1, 1'b0, 1'b0};
                        o_count = 2'd1;
                    end
                end
                esd_pkg::MODE_ESC: begin
                    o_next.mode = esd_pkg::MODE_NORMAL;
                    o_count     = 2'd1;
                    priority if (i_ch == esd_pkg::CH_LOWER_B) begin
                        o_res0 = '{esd_pkg::CTL_BS, 1'b1, 1'b0, 1'b0};
                    end else if (i_ch == esd_pkg::CH_LOWER_F) begin
                        o_res0 = '{esd_pkg::CTL_FF, 1'b1, 1'b0, 1'b0};
                    end else if (i_ch == esd_pkg::CH_LOWER_N) begin
                        o_res0 = '{esd_pkg::CTL_LF, 1'b1, 1'b0, 1'b0};
                    end else if (i_ch == esd_pkg::CH_LOWER_R) begin
                        o_res0 = '{esd_pkg::CTL_CR, 1'b1, 1'b0, 1'b0};
                    end else if (i_ch == esd_pkg::CH_LOWER_T) begin
                        o_res0 = '{esd_pkg::CTL_TAB, 1'b1, 1'b0, 1'b0};
                    end else if (i_ch == esd_pkg::CH_LOWER_X) begin
                        o_next.mode  = esd_pkg::MODE_HEX;
                        o_next.accum = 8'd0;
                        o_count      = 2'd0;
                    end else if (w_is_dec) begin
                        o_next.mode         = esd_pkg::MODE_OCT;
                        o_next.accum        = {4'd0, w_dec_val};
                        o_next.octal_count  = 2'd1;
                        o_next.warn_pending = w_over_seven;
                        o_count             = 2'd0;
                    end else begin
                        o_res0 = '{i_ch, 1'b1, 1'b0, 1'b0};
                    end
                end
                esd_pkg::MODE_HEX: begin
                    if (w_is_hex) begin
                        o_next.accum = {i_state.accum[3:0], w_hex_val};
                    end else begin
                        o_res0  = '{i_state.accum, 1'b1, 1'b0, 1'b0};
                        o_count = 2'd1;
                        o_next  = esd_pkg::DEC_STATE_RESET;
                        if (i_ch == esd_pkg::CH_BACKSLASH) begin
                            o_next.mode = esd_pkg::MODE_ESC;
                        end else begin
                            o_res1  = '{i_ch, 1'b1, 1'b0, 1'b0};
                            o_count = 2'd2;
                        end
                    end
                end
                esd_pkg::MODE_OCT: begin
                    if (w_is_dec) begin
                        o_next.warn_pending = i_state.warn_pending | w_over_seven;
                        o_next.accum        = {i_state.accum[4:0], 3'b000} + {4'd0, w_dec_val};
                        o_next.octal_count  = i_state.octal_count + 2'd1;
                        if (o_next.octal_count == esd_pkg::OCT_DIGITS_MAX) begin
                            o_res0  = '{o_next.accum, 1'b1, o_next.warn_pending, 1'b0};
                            o_count = 2'd1;
                            o_next  = esd_pkg::DEC_STATE_RESET;
                        end
                    end else begin
                        o_res0  = '{i_state.accum, 1'b1, i_state.warn_pending, 1'b0};
                        o_count = 2'd1;
                        o_next  = esd_pkg::DEC_STATE_RESET;
                        if (i_ch == esd_pkg::CH_BACKSLASH) begin
                            o_next.mode = esd_pkg::MODE_ESC;
                        end else begin
                            o_res1  = '{i_ch, 1'b1, 1'b0, 1'b0};
                            o_count = 2'd2;
                        end
                    end
                end
                default: begin
                    o_next = esd_pkg::DEC_STATE_RESET;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/c_escape_sequence_decoder.sv
// Escape sequence decoder: streams text bytes and an end marker, decodes C-style
// backslash escapes (letter, hex and octal forms) into output bytes. An item is
// registered on transfer, decoded in one pass against the escape state, and its
// results land in a two-entry result queue that drives the output channel. An item
// that makes zero or one result is retired whenever the queue has room, so one item
// is taken every cycle while the sink keeps up; an item that closes a pending escape
// can make two results (flushed value plus its own byte, or flushed value plus the
// end result) and then waits until the queue is empty after any pop, since the
// result queue drains one transfer per cycle. The first result of an item passes
// the input register and then the result queue register before it shows on the
// output. Input ready depends combinationally on output ready through the queue
// space check. The end marker always gives one closing result with done_res set.
// Depends on esd_pkg, esd_if, esd_decode and assert_macros.svh.
`include "assert_macros.svh"

module c_escape_sequence_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    esd_item_if.sink            i_item,
    esd_result_if.source        o_result
);

    // Input register
    logic                r_in_valid;
    logic                r_in_kind;
    logic [7:0]          r_in_ch;

    // Escape state
    esd_pkg::t_dec_state r_state;

    // Result queue: entry 0 is the head
    esd_pkg::t_result    r_q [esd_pkg::RESULT_DEPTH];
    esd_pkg::t_result    n_q [esd_pkg::RESULT_DEPTH];
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;

    esd_pkg::t_dec_state w_next;
    logic [1:0]          w_count;
    esd_pkg::t_result    w_res0;
    esd_pkg::t_result    w_res1;
    logic                w_pop;
    logic [1:0]          w_cnt_left;
    logic [2:0]          w_fill;
    logic                w_consume;

    esd_decode u_decode (
        .i_state (r_state),
        .i_kind  (r_in_kind),
        .i_ch    (r_in_ch),
        .o_next  (w_next),
        .o_count (w_count),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    // Retire the held item only when the queue has room for all its results
    assign w_pop      = o_result.valid && o_result.ready;
    assign w_cnt_left = r_cnt - {1'b0, w_pop};
    assign w_fill     = {1'b0, w_cnt_left} + {1'b0, w_count};
    assign w_consume  = r_in_valid && (w_fill <= 3'(esd_pkg::RESULT_DEPTH));

    assign i_item.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload until the next transfer
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind <= i_item.kind;
            r_in_ch   <= i_item.ch;
        end
    end

    // Advance the escape state once per retired item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esd_pkg::DEC_STATE_RESET;
        end else if (w_consume) begin
            r_state <= w_next;
        end
    end

    // Shift out the head on a pop, then append new results behind what is left
    always_comb begin
        n_q[0] = w_pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = w_cnt_left;
        if (w_consume) begin
            n_cnt = w_fill[1:0];
            if (w_cnt_left == 2'd0) begin
                n_q[0] = w_res0;
                n_q[1] = w_res1;
            end else if (w_cnt_left == 2'd1) begin
                n_q[1] = w_res0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_result.valid      = (r_cnt != 2'd0);
    assign o_result.out_byte   = r_q[0].out_byte;
    assign o_result.has_byte   = r_q[0].has_byte;
    assign o_result.octal_warn = r_q[0].octal_warn;
    assign o_result.done_res   = r_q[0].done_res;

    `ASSERT_CLKD(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'd2, "result queue overfilled")
    `ASSERT_CLKD(a_done_clean, i_clk, i_rst_n,
        (o_result.valid && o_result.done_res) |->
        (!o_result.has_byte && o_result.out_byte == 8'd0 && !o_result.octal_warn),
        "closing result carries data")
    `ASSERT_CLKD(a_warn_byte, i_clk, i_rst_n,
        (o_result.valid && o_result.octal_warn) |-> o_result.has_byte,
        "octal warning without a byte")
    `ASSERT_CLKD(a_end_resets, i_clk, i_rst_n,
        (w_consume && r_in_kind) |=> (r_state == esd_pkg::DEC_STATE_RESET),
        "end marker left escape state")
    `ASSERT_CLKD(a_end_results, i_clk, i_rst_n,
        (w_consume && r_in_kind) |-> (w_count != 2'd0),
        "end marker made no result")

endmodule
